@@ rtl/line_column_locator_top_defines.svh @@
// Assertion helpers used by the locator top level.
`ifndef LINE_COLUMN_LOCATOR_TOP_DEFINES_SVH
`define LINE_COLUMN_LOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LCL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lcl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lcl_pkg;

   localparam int MAX_LINES   = 1024;
   localparam int OFFSET_BITS = 20;
   localparam int ADDR_BITS   = $clog2(MAX_LINES);
   localparam int COUNT_BITS  = $clog2(MAX_LINES + 1);
   localparam int LEN_BITS    = OFFSET_BITS + 1;
   localparam int LINE_BITS   = 11;
   localparam int COL_BITS    = 21;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_RANGE    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [7:0]             data_byte;
      logic [OFFSET_BITS-1:0] query_offset;
   } req_word_type;

   typedef struct packed {
      logic [7:0]           out_byte;
      logic                 byte_valid;
      logic [LINE_BITS-1:0] line_number;
      logic [COL_BITS-1:0]  column_number;
      logic [1:0]           status;
      logic                 last;
   } rsp_word_type;

   // Write port of the LF offset table.
   typedef struct packed {
      logic                   en;
      logic [ADDR_BITS-1:0]   addr;
      logic [OFFSET_BITS-1:0] data;
   } ram_wr_type;

   // Search launch from the controller.
   typedef struct packed {
      logic                   start;
      logic [OFFSET_BITS-1:0] offset;
      logic [COUNT_BITS-1:0]  count;
   } search_cmd_type;

   // Search completion back to the controller.
   typedef struct packed {
      logic                 done;
      logic [LINE_BITS-1:0] line;
      logic [COL_BITS-1:0]  column;
   } search_rsp_type;

endpackage

`default_nettype wire

@@ rtl/lcl_offset_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lcl_offset_ram
   import lcl_pkg::*;
(
   input  wire logic                   clock,
   input  wire ram_wr_type             wr,
   input  wire logic                   rd_en,
   input  wire logic [ADDR_BITS-1:0]   rd_addr,
   output logic      [OFFSET_BITS-1:0] rd_data
);

   logic [OFFSET_BITS-1:0] mem [MAX_LINES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/lcl_search.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lcl_search
   import lcl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire search_cmd_type         cmd,
   output search_rsp_type              rsp,
   output logic                        rd_en,
   output logic      [ADDR_BITS-1:0]   rd_addr,
   input  wire logic [OFFSET_BITS-1:0] rd_data
);

   typedef enum logic [3:0] {
      SR_IDLE  = 4'b0001,
      SR_PROBE = 4'b0010,
      SR_CMP   = 4'b0100,
      SR_COL   = 4'b1000
   } sr_state_type;

   sr_state_type           state_ff, state_in;
   logic [COUNT_BITS-1:0]  lo_ff, lo_in;
   logic [COUNT_BITS-1:0]  hi_ff, hi_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;

   logic [COUNT_BITS:0]   sum;
   logic [COUNT_BITS-1:0] mid;
   logic [COUNT_BITS-1:0] lo_prev;
   logic [LEN_BITS-1:0]   diff;
   logic                  entry_less;
   logic                  open_range;

   // One subtractor serves both the probe compare and the column after a recorded LF.
   assign sum        = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = sum[COUNT_BITS:1];
   assign lo_prev    = lo_ff - COUNT_BITS'(1);
   assign diff       = {1'b0, off_ff} - {1'b0, rd_data};
   assign entry_less = !diff[OFFSET_BITS] && (diff != '0);
   assign open_range = lo_ff < hi_ff;

   assign rd_addr = open_range ? mid[ADDR_BITS-1:0] : lo_prev[ADDR_BITS-1:0];
   assign rd_en   = (state_ff == SR_PROBE);

   always_comb begin
      state_in   = state_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      off_in     = off_ff;
      rsp.done   = 1'b0;
      rsp.line   = LINE_BITS'(lo_ff) + LINE_BITS'(1);
      rsp.column = diff;
      case (state_ff)
         SR_IDLE: begin
            if (cmd.start) begin
               lo_in    = '0;
               hi_in    = cmd.count;
               off_in   = cmd.offset;
               state_in = SR_PROBE;
            end
         end
         SR_PROBE: begin
            if (open_range) begin
               state_in = SR_CMP;
            end else if (lo_ff == '0) begin
               rsp.done   = 1'b1;
               rsp.column = {1'b0, off_ff} + LEN_BITS'(1);
               state_in   = SR_IDLE;
            end else begin
               state_in = SR_COL;
            end
         end
         SR_CMP: begin
            if (entry_less) begin
               lo_in = mid + COUNT_BITS'(1);
            end else begin
               hi_in = mid;
            end
            state_in = SR_PROBE;
         end
         SR_COL: begin
            rsp.done = 1'b1;
            state_in = SR_IDLE;
         end
         default: begin
            state_in = SR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      off_ff <= off_in;
   end

endmodule

`default_nettype wire

@@ rtl/line_column_locator_top.sv @@
// Line and column locator for one source text.
// The req channel carries one word per item: a clear, an appended raw byte or an
// offset query. The rsp channel returns result words; the word that ends an item
// has last set. An append gives zero, one or two byte words (a CR is held back
// until the next byte shows whether it starts a CRLF pair), a query gives one.
// An append result appears in the cycle after acceptance; a two-byte append loads
// its second word into the output register as the first one leaves it.
// A query runs a binary search of the LF offset table. Each probe is a table
// read followed by a compare in the shared subtractor. Queries that end early
// (overflow, empty text, out of range) are answered without a search. The block
// takes one item at a time.
// Reset clears the held CR, the length, the LF count and the overflow flag; the
// table itself needs no clearing since only recorded entries are ever read.
// When the receiver stalls, the result word holds in the output register and
// req_stall stays high until that register can take the next word.
`timescale 1ns / 1ps
`default_nettype none
`include "line_column_locator_top_defines.svh"

module line_column_locator_top
   import lcl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EMIT2  = 3'b010,
      ST_SEARCH = 3'b100
   } st_state_type;

   st_state_type          state_ff, state_in;
   logic                  pending_ff, pending_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic [7:0]            held_ff, held_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic            out_free;
   logic            accept;
   logic            emit_en;
   logic [7:0]      emit_byte;
   logic            emit_last;
   logic            clear_now;
   ram_wr_type      ram_wr;
   search_cmd_type  srch_cmd;
   search_rsp_type  srch_rsp;
   logic            ram_rd_en;
   logic [ADDR_BITS-1:0]   ram_rd_addr;
   logic [OFFSET_BITS-1:0] ram_rd_data;
   logic [LEN_BITS-1:0]    query_len;

   // The output register can take a word when it is empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign query_len = {1'b0, req_word.query_offset};

   // Item decode: which byte is emitted this cycle, and what happens next.
   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      held_in    = held_ff;
      emit_en    = 1'b0;
      emit_byte  = req_word.data_byte;
      emit_last  = 1'b1;
      clear_now  = 1'b0;
      srch_cmd.start  = 1'b0;
      srch_cmd.offset = req_word.query_offset;
      srch_cmd.count  = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_word.req_type)
                  REQ_CLEAR: begin
                     clear_now  = 1'b1;
                     pending_in = 1'b0;
                  end
                  REQ_APPEND: begin
                     if (!pending_ff) begin
                        if (req_word.data_byte == CHAR_CR) begin
                           pending_in = 1'b1;
                        end else begin
                           emit_en = 1'b1;
                        end
                     end else if (req_word.data_byte == CHAR_CR) begin
                        emit_en = 1'b1;
                     end else if (req_word.data_byte == CHAR_LF) begin
                        pending_in = 1'b0;
                        emit_en    = 1'b1;
                     end else begin
                        // A lone CR goes out first; the new byte follows.
                        pending_in = 1'b0;
                        emit_en    = 1'b1;
                        emit_byte  = CHAR_CR;
                        emit_last  = 1'b0;
                        held_in    = req_word.data_byte;
                        state_in   = ST_EMIT2;
                     end
                  end
                  REQ_QUERY: begin
                     if (!ovf_ff && (len_ff != '0) && (query_len < len_ff)) begin
                        srch_cmd.start = 1'b1;
                        state_in       = ST_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EMIT2: begin
            emit_byte = held_ff;
            if (out_free) begin
               emit_en  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (srch_rsp.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Counting of emitted bytes and recording of LF offsets.
   always_comb begin
      len_in      = len_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      ram_wr.en   = 1'b0;
      ram_wr.addr = count_ff[ADDR_BITS-1:0];
      ram_wr.data = len_ff[OFFSET_BITS-1:0];
      if (clear_now) begin
         len_in   = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (emit_en) begin
         if (len_ff[OFFSET_BITS]) begin
            ovf_in = 1'b1;
         end else begin
            if (emit_byte == CHAR_LF) begin
               if (count_ff == COUNT_BITS'(MAX_LINES)) begin
                  ovf_in = 1'b1;
               end else begin
                  ram_wr.en = 1'b1;
                  count_in  = count_ff + COUNT_BITS'(1);
               end
            end
            len_in = len_ff + LEN_BITS'(1);
         end
      end
   end

   // Output register loading.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (emit_en) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.out_byte      = emit_byte;
         rsp_word_in.byte_valid    = 1'b1;
         rsp_word_in.line_number   = '0;
         rsp_word_in.column_number = '0;
         rsp_word_in.status        = ovf_in ? STATUS_OVERFLOW : STATUS_OK;
         rsp_word_in.last          = emit_last;
      end else if (accept && (req_word.req_type == REQ_QUERY) && !srch_cmd.start) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.out_byte      = '0;
         rsp_word_in.byte_valid    = 1'b0;
         rsp_word_in.line_number   = '0;
         rsp_word_in.column_number = '0;
         rsp_word_in.status        = STATUS_OK;
         rsp_word_in.last          = 1'b1;
         if (ovf_ff) begin
            rsp_word_in.status = STATUS_OVERFLOW;
         end else if (len_ff == '0) begin
            rsp_word_in.line_number = LINE_BITS'(1);
         end else begin
            rsp_word_in.status = STATUS_RANGE;
         end
      end else if ((state_ff == ST_SEARCH) && srch_rsp.done) begin
         rsp_valid_in              = 1'b1;
         rsp_word_in.out_byte      = '0;
         rsp_word_in.byte_valid    = 1'b0;
         rsp_word_in.line_number   = srch_rsp.line;
         rsp_word_in.column_number = srch_rsp.column;
         rsp_word_in.status        = STATUS_OK;
         rsp_word_in.last          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 1'b0;
         len_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The LF offset table.
   lcl_offset_ram u_offset_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The lower-bound search over the table.
   lcl_search u_search (
      .clock   (clock),
      .reset   (reset),
      .cmd     (srch_cmd),
      .rsp     (srch_rsp),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // A busy controller never takes a new word.
   `LCL_ASSERT_NOW(a_busy_stalls, clock, reset, state_ff != ST_IDLE, req_stall,
      "request accepted while the controller is busy")

   // A search finishes only while the controller waits for it.
   `LCL_ASSERT_NOW(a_done_in_search, clock, reset, srch_rsp.done, state_ff == ST_SEARCH,
      "search completion outside a query")

   // The LF count and the length never pass their limits.
   `LCL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      (count_ff <= COUNT_BITS'(MAX_LINES)) && (len_ff <= (LEN_BITS'(1) << OFFSET_BITS)),
      "LF count or text length beyond its limit")

   // A successful query result always names a line.
   `LCL_ASSERT_NOW(a_query_line, clock, reset,
      rsp_valid_ff && !rsp_word_ff.byte_valid && (rsp_word_ff.status == STATUS_OK),
      rsp_word_ff.line_number != '0,
      "query result without a line number")

endmodule

`default_nettype wire
